>>> hw/rtl/sorted_key_table_assert.svh
// Assertion macros used by the sorted key table datapath.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define SKT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted key table assertion failed");

// Clocked check that also holds during reset.
`define SKT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("sorted key table assertion failed");

`endif

>>> hw/rtl/skt_pkg.sv
package skt_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_ADJUST = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RES_FULL,
    RES_DUP,
    RES_MISSING,
    RES_INSERTED,
    RES_FOUND
  } res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_CHK,
    S_SHIFT_WR
  } state_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned EntryW = KeyW + CountW;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;       // capture the item and clear the index
    logic scan_rd;   // read the entry at the index
    logic inc;       // advance the index
    logic mark_pos;  // remember the insert position, index to the fill count
    logic shift_rd;  // read the entry below the index
    logic shift_wr;  // move that entry up to the index, index down by one
    logic place;     // write the new pair at the insert position
    logic adj_wr;    // write back the adjusted count at the index
    logic res;       // load the result registers
    res_e res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_insert;
    logic is_adjust;
    logic full;
    logic scan_end;
    logic hit;
    logic above;
    logic at_pos;
  } sts_t;

endpackage

>>> hw/rtl/skt_ram.sv
module skt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/skt_ctrl.sv
module skt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  skt_pkg::sts_t sts_i,
  output skt_pkg::cmd_t cmd_o
);
  import skt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_MISSING;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.is_insert && sts_i.full) begin
          cmd_o.res     = 1'b1;
          cmd_o.res_sel = RES_FULL;
          state_d       = S_IDLE;
        end else if (sts_i.scan_end) begin
          if (sts_i.is_insert) begin
            // The new key is above every stored key: it goes at the end.
            cmd_o.mark_pos = 1'b1;
            state_d        = S_SHIFT_CHK;
          end else begin
            cmd_o.res     = 1'b1;
            cmd_o.res_sel = RES_MISSING;
            state_d       = S_IDLE;
          end
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.hit) begin
          cmd_o.res = 1'b1;
          if (sts_i.is_insert) begin
            cmd_o.res_sel = RES_DUP;
          end else begin
            cmd_o.adj_wr  = sts_i.is_adjust;
            cmd_o.res_sel = RES_FOUND;
          end
          state_d = S_IDLE;
        end else if (sts_i.is_insert && sts_i.above) begin
          // Keys are sorted, so no duplicate can follow a larger key.
          cmd_o.mark_pos = 1'b1;
          state_d        = S_SHIFT_CHK;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = S_SCAN_RD;
        end
      end
      S_SHIFT_CHK: begin
        if (sts_i.at_pos) begin
          cmd_o.place   = 1'b1;
          cmd_o.res     = 1'b1;
          cmd_o.res_sel = RES_INSERTED;
          state_d       = S_IDLE;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_CHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hw/rtl/skt_dp.sv
module skt_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          kind_i,
  input  logic signed [skt_pkg::KeyW-1:0]     key_i,
  input  logic signed [skt_pkg::CountW-1:0]   amount_i,
  input  skt_pkg::cmd_t                       cmd_i,
  output skt_pkg::sts_t                       sts_o,
  output logic [1:0]                          status_o,
  output logic signed [skt_pkg::CountW-1:0]   count_value_o,
  output logic [skt_pkg::SlotW-1:0]           slot_o,
  output logic                                result_valid_o
);
  import skt_pkg::*;
  `include "sorted_key_table_assert.svh"

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + SlotW;

  logic [1:0]               kind_q;
  logic signed [KeyW-1:0]   key_q;
  logic signed [CountW-1:0] amount_q;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            pos_q;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [1:0]               status_q, status_d;
  logic signed [CountW-1:0] value_q, value_d;
  logic [SlotW-1:0]         slot_q, slot_d;
  logic                     done_q;

  logic [EntryW-1:0]        rdata;
  logic signed [KeyW-1:0]   rd_key;
  logic signed [CountW-1:0] rd_cnt;
  logic signed [CountW:0]   sum;
  logic signed [CountW-1:0] sat;
  logic [CW-1:0]            idx_m1;
  logic [CW-1:0]            raddr_full;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EntryW-1:0]        ram_wdata;
  logic [XW-1:0]            idx_ext, pos_ext;

  assign rd_key = rdata[EntryW-1:CountW];
  assign rd_cnt = rdata[CountW-1:0];

  // Saturating add: overflow shows as the two top bits of the sum differing.
  assign sum = {rd_cnt[CountW-1], rd_cnt} + {amount_q[CountW-1], amount_q};
  always_comb begin
    if (sum[CountW] != sum[CountW-1]) begin
      sat = sum[CountW] ? {1'b1, {(CountW-1){1'b0}}} : {1'b0, {(CountW-1){1'b1}}};
    end else begin
      sat = sum[CountW-1:0];
    end
  end

  assign idx_m1     = idx_q - CW'(1);
  assign raddr_full = cmd_i.shift_rd ? idx_m1 : idx_q;
  assign ram_we     = cmd_i.shift_wr | cmd_i.place | cmd_i.adj_wr;
  assign ram_waddr  = cmd_i.place ? pos_q[AW-1:0] : idx_q[AW-1:0];

  always_comb begin
    if (cmd_i.shift_wr) begin
      ram_wdata = rdata;
    end else if (cmd_i.place) begin
      ram_wdata = {key_q, amount_q};
    end else begin
      ram_wdata = {key_q, sat};
    end
  end

  skt_ram #(
    .WIDTH(EntryW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.scan_rd | cmd_i.shift_rd),
    .raddr_i(raddr_full[AW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.cap) begin
      idx_d = '0;
    end else if (cmd_i.inc) begin
      idx_d = idx_q + CW'(1);
    end else if (cmd_i.mark_pos) begin
      idx_d = cnt_q;
    end else if (cmd_i.shift_wr) begin
      idx_d = idx_m1;
    end
  end

  assign cnt_d = cmd_i.place ? cnt_q + CW'(1) : cnt_q;

  assign idx_ext = {{SlotW{1'b0}}, idx_q};
  assign pos_ext = {{SlotW{1'b0}}, pos_q};

  always_comb begin
    status_d = ST_OK;
    value_d  = '0;
    slot_d   = '0;
    case (cmd_i.res_sel)
      RES_FULL:    status_d = ST_FULL;
      RES_DUP:     status_d = ST_DUP;
      RES_MISSING: status_d = ST_MISSING;
      RES_INSERTED: begin
        value_d = amount_q;
        slot_d  = pos_ext[SlotW-1:0];
      end
      RES_FOUND: begin
        value_d = (kind_q == KIND_ADJUST) ? sat : rd_cnt;
        slot_d  = idx_ext[SlotW-1:0];
      end
      default: status_d = ST_MISSING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= cmd_i.res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q   <= kind_i;
      key_q    <= key_i;
      amount_q <= amount_i;
    end
    idx_q <= idx_d;
    if (cmd_i.mark_pos) begin
      pos_q <= idx_q;
    end
    if (cmd_i.res) begin
      status_q <= status_d;
      value_q  <= value_d;
      slot_q   <= slot_d;
    end
  end

  assign sts_o.is_insert = (kind_q == KIND_INSERT);
  assign sts_o.is_adjust = (kind_q == KIND_ADJUST);
  assign sts_o.full      = (cnt_q == CW'(CAPACITY));
  assign sts_o.scan_end  = (idx_q == cnt_q);
  assign sts_o.hit       = (rd_key == key_q);
  assign sts_o.above     = (rd_key > key_q);
  assign sts_o.at_pos    = (idx_q == pos_q);

  assign status_o       = status_q;
  assign count_value_o  = value_q;
  assign slot_o         = slot_q;
  assign result_valid_o = done_q;

  `SKT_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY))
  `SKT_ASSERT(a_place_grows, cmd_i.place |=> cnt_q == $past(cnt_q) + CW'(1))
  `SKT_ASSERT(a_fail_zero, (done_q && status_q != ST_OK) |-> (value_q == '0 && slot_q == '0))
  `SKT_ASSERT(a_shift_above_pos, cmd_i.shift_wr |-> idx_q > pos_q)

endmodule

>>> hw/rtl/sorted_key_table.sv
// Sorted key table: one item at a time, busy is high from the accept edge until the result.
// A lookup or adjust reads, then compares, the stored keys in turn from slot 0 until a hit or
// the fill count; an insert scans the same way to the first larger key, then moves each entry
// from there on up by one slot and writes the new pair, all via the single registered read port.
// Reset clears the fill count and the controller; the store itself is not cleared.
// The result is shown for one cycle with result_valid_o; the receiver cannot stall it.
module sorted_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        kind_i,
  input  logic signed [skt_pkg::KeyW-1:0]   key_i,
  input  logic signed [skt_pkg::CountW-1:0] amount_i,
  output logic [1:0]                        status_o,
  output logic signed [skt_pkg::CountW-1:0] count_value_o,
  output logic [skt_pkg::SlotW-1:0]         slot_o,
  output logic                              result_valid_o
);
  import skt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .busy_o(busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  skt_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .amount_i      (amount_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .count_value_o (count_value_o),
    .slot_o        (slot_o),
    .result_valid_o(result_valid_o)
  );

endmodule
